// File: design/lcd_smt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCD scanline and mode timing package
// Mode codes, dot and line limits and register indexes shared by the block.
// ----------------------------------------------------------------------------
package lcd_smt_pkg;

    // Display modes as reported on cur_mode
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DISPLAY_ENABLE = 2'd0,
        REG_LINE_COMPARE   = 2'd1,
        REG_STAT_ENABLES   = 2'd2,
        REG_UNUSED         = 2'd3
    } lcd_reg_t;

    localparam int unsigned DOT_W  = 9;
    localparam int unsigned LINE_W = 8;

    localparam logic [DOT_W-1:0]  DOTS_PER_CYCLE    = 9'd4;
    localparam logic [DOT_W-1:0]  SEARCH_DOTS       = 9'd80;
    localparam logic [DOT_W-1:0]  TRANSFER_DOTS     = 9'd172;
    localparam logic [DOT_W-1:0]  HBLANK_DOTS       = 9'd204;
    localparam logic [DOT_W-1:0]  LINE_DOTS         = 9'd456;
    localparam logic [LINE_W-1:0] LAST_VISIBLE_LINE = 8'd143;
    localparam logic [LINE_W-1:0] LINES_PER_FRAME   = 8'd154;

    // STAT interrupt enable bit positions
    localparam int unsigned EN_HBLANK  = 0;
    localparam int unsigned EN_VBLANK  = 1;
    localparam int unsigned EN_SEARCH  = 2;
    localparam int unsigned EN_COMPARE = 3;

endpackage
`default_nettype wire

// File: design/lcd_scanline_mode_timing_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCD scanline and mode timing
// Results are registered: a result appears in the cycle after its request is taken.
// Throughput: one request per cycle; the output register refills while its
//   result is taken, so the only pause is a stall on the result side.
// Reset: asynchronous; display disabled, line and dots zero, search mode,
//   compare value and STAT enables zero, no result pending.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timing_top
    import lcd_smt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        advance,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       cur_mode,
    output logic [7:0]       cur_line,
    output logic             coincidence,
    output logic             vblank_irq,
    output logic             stat_irq,
    output logic             line_done
);

    // Configuration registers
    logic              display_enable_reg;
    logic [LINE_W-1:0] line_compare_reg;
    logic [3:0]        stat_en_reg;

    // Timing state
    logic [DOT_W-1:0]  dot_reg,  dot_next;
    logic [LINE_W-1:0] line_reg, line_next;
    lcd_mode_t         mode_reg, mode_next;

    // Result register
    logic              out_valid_reg;
    lcd_mode_t         res_mode_reg;
    logic [LINE_W-1:0] res_line_reg;
    logic              res_coin_reg;
    logic              res_vblank_reg;
    logic              res_stat_reg;
    logic              res_done_reg;

    logic              vblank_next, stat_next, done_next;
    logic              in_take, out_take, cfg_take;
    logic [DOT_W-1:0]  dot_inc;
    logic [LINE_W-1:0] line_inc;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_take   = in_valid && !in_stall;

    assign dot_inc  = dot_reg + DOTS_PER_CYCLE;
    assign line_inc = line_reg + 8'd1;

    // Step the timing for one request
    always_comb
    begin
        dot_next    = dot_reg;
        line_next   = line_reg;
        mode_next   = mode_reg;
        vblank_next = 1'b0;
        stat_next   = 1'b0;
        done_next   = 1'b0;
        if (advance && display_enable_reg)
        begin
            dot_next = dot_inc;
            case (mode_reg)
                MODE_SEARCH:
                begin
                    if (dot_inc == DOTS_PER_CYCLE && stat_en_reg[EN_COMPARE]
                        && line_compare_reg == line_reg)
                        stat_next = 1'b1;
                    if (dot_inc >= SEARCH_DOTS)
                    begin
                        mode_next = MODE_TRANSFER;
                        dot_next  = '0;
                    end
                end
                MODE_TRANSFER:
                begin
                    if (dot_inc >= TRANSFER_DOTS)
                    begin
                        mode_next = MODE_HBLANK;
                        dot_next  = '0;
                        stat_next = stat_en_reg[EN_HBLANK];
                    end
                end
                MODE_HBLANK:
                begin
                    if (dot_inc >= HBLANK_DOTS)
                    begin
                        done_next = 1'b1;
                        dot_next  = '0;
                        line_next = line_inc;
                        if (line_reg == LAST_VISIBLE_LINE)
                        begin
                            mode_next   = MODE_VBLANK;
                            vblank_next = 1'b1;
                            stat_next   = stat_en_reg[EN_VBLANK];
                        end
                        else
                        begin
                            mode_next = MODE_SEARCH;
                            stat_next = stat_en_reg[EN_SEARCH];
                        end
                    end
                end
                default:
                begin
                    if (dot_inc >= LINE_DOTS)
                    begin
                        dot_next  = '0;
                        line_next = line_inc;
                        if (line_inc == LINES_PER_FRAME)
                        begin
                            line_next = '0;
                            mode_next = MODE_SEARCH;
                            stat_next = stat_en_reg[EN_SEARCH];
                        end
                    end
                end
            endcase
        end
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg <= 1'b0;
            line_compare_reg   <= '0;
            stat_en_reg        <= '0;
        end
        else if (cfg_take)
        begin
            case (lcd_reg_t'(cfg_index))
                REG_DISPLAY_ENABLE: display_enable_reg <= cfg_data[0];
                REG_LINE_COMPARE:   line_compare_reg   <= cfg_data;
                REG_STAT_ENABLES:   stat_en_reg        <= cfg_data[3:0];
                default:            ;
            endcase
        end
    end

    // Advance timing state; disabling the display drops it to the start of line zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            line_reg <= '0;
            mode_reg <= MODE_SEARCH;
        end
        else if (cfg_take && lcd_reg_t'(cfg_index) == REG_DISPLAY_ENABLE && !cfg_data[0])
        begin
            dot_reg  <= '0;
            line_reg <= '0;
            mode_reg <= MODE_SEARCH;
        end
        else if (in_take)
        begin
            dot_reg  <= dot_next;
            line_reg <= line_next;
            mode_reg <= mode_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_take)
            out_valid_reg <= 1'b1;
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            res_mode_reg   <= mode_next;
            res_line_reg   <= line_next;
            res_coin_reg   <= (line_next == line_compare_reg);
            res_vblank_reg <= vblank_next;
            res_stat_reg   <= stat_next;
            res_done_reg   <= done_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cur_mode    = res_mode_reg;
    assign cur_line    = res_line_reg;
    assign coincidence = res_coin_reg;
    assign vblank_irq  = res_vblank_reg;
    assign stat_irq    = res_stat_reg;
    assign line_done   = res_done_reg;

    // Dot counter only ever moves in whole machine cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        dot_reg[1:0] == 2'b00)
        else $error("dot counter off a machine-cycle boundary");

    // Visible modes only occur on visible lines
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_TRANSFER || mode_reg == MODE_HBLANK) |->
        line_reg <= LAST_VISIBLE_LINE)
        else $error("transfer or hblank outside visible lines");

    // Entering vblank always closes the last visible line and reports line 144
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_vblank_reg) |->
        (res_done_reg && res_mode_reg == MODE_VBLANK
         && res_line_reg == LAST_VISIBLE_LINE + 8'd1))
        else $error("vblank pulse without end of last visible line");

    // Lines never run past the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        line_reg < LINES_PER_FRAME)
        else $error("line number beyond frame");

endmodule
`default_nettype wire

// File: bench/lcd_scanline_mode_timing_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD scanline and mode timing testbench
// Drives machine-cycle ticks into the timing block under random source gaps
// and sink stalls, keeps a cycle-true copy of the dot, line and mode state,
// and compares every reported mode, line, flag and pulse against it. A full
// frame walk covers vertical blank and the wrap back to line zero.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timing_top_test;
    import lcd_smt_pkg::*;

    // One report as seen on the result channel
    typedef struct packed {
        lcd_mode_t        mode;
        logic [LINE_W-1:0] line_no;
        logic             coin;
        logic             vbl;
        logic             stat;
        logic             done;
    } scan_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        advance = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  cur_mode;
    logic [7:0]  cur_line;
    logic        coincidence;
    logic        vblank_irq;
    logic        stat_irq;
    logic        line_done;

    // Shadow of the timing state and registers
    logic [DOT_W-1:0]  dot_cnt = '0;
    logic [LINE_W-1:0] line_q = '0;
    lcd_mode_t         mode_q = MODE_SEARCH;
    logic              disp_en = 1'b0;
    logic [7:0]        line_cmp = '0;
    logic [3:0]        stat_en = '0;

    scan_report_t pending_reports_q[$];

    int unsigned send_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned sink_hold_left = 0;

    int unsigned mismatch_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned reports_seen = 0;
    int unsigned vblank_pulses = 0;
    int unsigned stat_pulses = 0;
    int unsigned done_pulses = 0;

    lcd_scanline_mode_timing_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cur_mode    (cur_mode),
        .cur_line    (cur_line),
        .coincidence (coincidence),
        .vblank_irq  (vblank_irq),
        .stat_irq    (stat_irq),
        .line_done   (line_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Step the shadow timing by one request and return the report it produces
    function automatic scan_report_t advance_timing(input logic tick);
        scan_report_t r;
        r = '0;
        if (tick && disp_en)
        begin
            dot_cnt = dot_cnt + DOTS_PER_CYCLE;
            case (mode_q)
                MODE_SEARCH:
                begin
                    if (dot_cnt == DOTS_PER_CYCLE && stat_en[EN_COMPARE] && line_cmp == line_q)
                        r.stat = 1'b1;
                    if (dot_cnt >= SEARCH_DOTS)
                    begin
                        mode_q = MODE_TRANSFER;
                        dot_cnt = '0;
                    end
                end
                MODE_TRANSFER:
                begin
                    if (dot_cnt >= TRANSFER_DOTS)
                    begin
                        mode_q = MODE_HBLANK;
                        dot_cnt = '0;
                        if (stat_en[EN_HBLANK])
                            r.stat = 1'b1;
                    end
                end
                MODE_HBLANK:
                begin
                    if (dot_cnt >= HBLANK_DOTS)
                    begin
                        r.done = 1'b1;
                        if (line_q == LAST_VISIBLE_LINE)
                        begin
                            mode_q = MODE_VBLANK;
                            r.vbl = 1'b1;
                            if (stat_en[EN_VBLANK])
                                r.stat = 1'b1;
                        end
                        else
                        begin
                            mode_q = MODE_SEARCH;
                            if (stat_en[EN_SEARCH])
                                r.stat = 1'b1;
                        end
                        dot_cnt = '0;
                        line_q = line_q + 8'd1;
                    end
                end
                default:
                begin
                    if (dot_cnt >= LINE_DOTS)
                    begin
                        line_q = line_q + 8'd1;
                        dot_cnt = '0;
                        if (line_q == LINES_PER_FRAME)
                        begin
                            line_q = '0;
                            mode_q = MODE_SEARCH;
                            if (stat_en[EN_SEARCH])
                                r.stat = 1'b1;
                        end
                    end
                end
            endcase
        end
        r.mode = mode_q;
        r.line_no = line_q;
        r.coin = (line_q == line_cmp);
        return r;
    endfunction

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input lcd_reg_t idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DISPLAY_ENABLE:
            begin
                disp_en = data[0];
                if (!data[0])
                begin
                    dot_cnt = '0;
                    line_q = '0;
                    mode_q = MODE_SEARCH;
                end
            end
            REG_LINE_COMPARE: line_cmp = data;
            REG_STAT_ENABLES: stat_en = data[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one tick request, with a random gap first, and log its report
    task automatic send_tick(input logic tick);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        advance <= tick;
        do
            @(posedge clk);
        while (in_stall);
        pending_reports_q = {pending_reports_q, advance_timing(tick)};
        ticks_sent++;
    endtask

    // Drop the request line and wait for every report to come back
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // Sink side: random stalls, or a counted hold when one is requested
    always @(negedge clk)
    begin
        if (sink_hold_left > 0)
        begin
            out_stall <= 1'b1;
            sink_hold_left = sink_hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Compare each accepted report with the oldest one logged
    always @(posedge clk)
    begin : check_reports
        scan_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected report, expected none, actual mode %0d line %0d",
                         $time, cur_mode, cur_line);
            end
            else
            begin
                want = pending_reports_q.pop_front();
                reports_seen++;
                vblank_pulses += vblank_irq;
                stat_pulses += stat_irq;
                done_pulses += line_done;
                check_field("cur_mode", want.mode, cur_mode);
                check_field("cur_line", want.line_no, cur_line);
                check_field("coincidence", want.coin, coincidence);
                check_field("vblank_irq", want.vbl, vblank_irq);
                check_field("stat_irq", want.stat, stat_irq);
                check_field("line_done", want.done, line_done);
            end
        end
    end

    // Display off: time stands still, compare flag still follows the register
    task automatic test_display_off();
        send_tick(1'b0);
        send_tick(1'b1);
        settle_block();
        write_reg(REG_LINE_COMPARE, 8'hFF);
        write_reg(REG_STAT_ENABLES, 8'hFF);
        write_reg(REG_UNUSED, 8'hA5);
        send_tick(1'b1);
        send_tick(1'b0);
        settle_block();
    endtask

    // Enable, compare hit on the first search cycle, no-time ticks,
    // re-enable while running and a disable in the middle of a line
    task automatic test_enable_and_hold();
        write_reg(REG_LINE_COMPARE, 8'h00);
        write_reg(REG_DISPLAY_ENABLE, 8'hFF);
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (3) send_tick(1'b1);
        settle_block();
        write_reg(REG_DISPLAY_ENABLE, 8'h01);
        repeat (2) send_tick(1'b1);
        settle_block();
        write_reg(REG_DISPLAY_ENABLE, 8'hFE);
        repeat (2) send_tick(1'b1);
        settle_block();
        write_reg(REG_STAT_ENABLES, 8'h08);
        write_reg(REG_DISPLAY_ENABLE, 8'h01);
        repeat (2) send_tick(1'b1);
        settle_block();
    endtask

    // Random ticks under one idling profile, with fresh register settings
    task automatic test_random_phase(input int unsigned count, input int unsigned gap_pct,
                                     input int unsigned stall_pct);
        logic [7:0] cmp;
        settle_block();
        send_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        if ($urandom_range(3) == 0)
        begin
            write_reg(REG_DISPLAY_ENABLE, 8'h00);
            write_reg(REG_DISPLAY_ENABLE, 8'h01);
        end
        cmp = ($urandom_range(4) == 0) ? 8'hFF : 8'($urandom_range(7));
        write_reg(REG_LINE_COMPARE, cmp);
        write_reg(REG_STAT_ENABLES, 8'($urandom_range(15)));
        repeat (count) send_tick($urandom_range(9) != 0);
    endtask

    // Walk a whole frame: visible lines, vertical blank and the wrap
    task automatic test_frame_walk();
        settle_block();
        write_reg(REG_LINE_COMPARE, 8'($urandom_range(1, LAST_VISIBLE_LINE)));
        write_reg(REG_STAT_ENABLES, 8'h0F);
        while (line_q < 8'd140)
            send_tick($urandom_range(7) != 0);
        settle_block();
        write_reg(REG_LINE_COMPARE, 8'($urandom_range(LAST_VISIBLE_LINE + 1, 153)));
        write_reg(REG_STAT_ENABLES, 8'h06);
        while (line_q != 8'd153)
            send_tick($urandom_range(7) != 0);
        settle_block();
        write_reg(REG_LINE_COMPARE, LAST_VISIBLE_LINE);
        write_reg(REG_STAT_ENABLES, 8'($urandom_range(15)));
        while (line_q != 8'd2)
            send_tick($urandom_range(7) != 0);
    endtask

    // Hold the sink for a long stretch while requests keep coming
    task automatic test_backpressure();
        settle_block();
        @(posedge clk);
        sink_hold_left = 40;
        repeat (60) send_tick(1'b1);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_display_off();
        test_enable_and_hold();
        test_random_phase(580, 15, 65);
        test_random_phase(580, 65, 15);
        test_random_phase(580, 0, 0);
        test_frame_walk();
        test_backpressure();

        settle_block();
        repeat (5) @(posedge clk);
        $display("covered %0d ticks and %0d reports across a full frame and wrap,",
                 ticks_sent, reports_seen);
        $display("with %0d vblank, %0d STAT and %0d line-end pulses",
                 vblank_pulses, stat_pulses, done_pulses);
        if (mismatch_count == 0)
            $display("lcd_scanline_mode_timing_top_test: done, clean");
        else
            $display("lcd_scanline_mode_timing_top_test: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("timeout with %0d reports outstanding", pending_reports_q.size());
        $display("lcd_scanline_mode_timing_top_test: done, errors");
        $finish;
    end

endmodule
